>>> hdl/antenna_relay_matrix_mapper_macros.svh
// ----------------------------------------------------------------------------
// Antenna relay matrix mapper assertion macros
// Shared property shorthands for the checker of the relay mapper.
// ----------------------------------------------------------------------------
`ifndef ANTENNA_RELAY_MATRIX_MAPPER_MACROS_SVH
`define ANTENNA_RELAY_MATRIX_MAPPER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define ARM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define ARM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/arm_pkg.sv
// ----------------------------------------------------------------------------
// Antenna relay matrix mapper package
// Widths, register indexes, operation codes and shared structures.
// ----------------------------------------------------------------------------
package arm_pkg;

  // Field widths.
  localparam int IMG_W      = 40;
  localparam int ANT_W      = 8;
  localparam int RADIO_W    = 8;
  localparam int MASK_W     = 5;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;

  // Radios served per bank.
  localparam int NUM_RADIOS = 4;

  // Highest antenna number that can drive a relay.
  localparam logic [ANT_W-1:0] ANT_MAX = ANT_W'(40);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIO_BANK   = 4'd0,
    CFG_GROUP_A_MASK = 4'd1,
    CFG_GROUP_B_MASK = 4'd2,
    CFG_FORCE_TWO    = 4'd3
  } cfg_index_t;

  // Operation codes of an input beat.
  localparam logic OP_REPORT     = 1'b0;
  localparam logic OP_SOFT_RESET = 1'b1;

  // Mapping configuration seen by every cell.
  typedef struct packed {
    logic              two_by_four;
    logic [MASK_W-1:0] a_mask;
    logic [MASK_W-1:0] b_mask;
  } map_cfg_t;

  // Store update command broadcast along the row of cells.
  typedef struct packed {
    logic             wr;
    logic             clr;
    logic [ANT_W-1:0] ant;
  } cell_ctrl_t;

endpackage

>>> hdl/arm_cell.sv
// ----------------------------------------------------------------------------
// Antenna relay matrix mapper cell
// Holds the antenna of one radio position and adds its relay bits to the
// image handed along the row.
// ----------------------------------------------------------------------------
module arm_cell
  import arm_pkg::*;
#(
  parameter int POS = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             sel,
  input  cell_ctrl_t       ctrl,
  input  map_cfg_t         cfg,
  input  logic [IMG_W-1:0] img_in,
  output logic [IMG_W-1:0] img_out,
  output logic             same
);

  localparam int PAIR    = (POS / 2) * 2;
  localparam int BUS_BIT = 32 + POS;
  localparam int BYTE_LO = 8 * POS;

  logic [ANT_W-1:0]  entry;
  logic [ANT_W-1:0]  ant_m1;
  logic              in_range;
  logic [MASK_W-1:0] gb;
  logic              a_hit;
  logic              b_hit;
  logic [5:0]        ofs;
  logic [IMG_W-1:0]  contrib;

  // Stored antenna; soft reset clears every cell at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else if (ctrl.clr) begin
      entry <= '0;
    end else if (ctrl.wr && sel) begin
      entry <= ctrl.ant;
    end
  end

  assign same = (entry == ctrl.ant);

  // Antenna group of eight and its port wiring.
  assign ant_m1   = entry - ANT_W'(1);
  assign in_range = (entry != '0) && (entry <= ANT_MAX);
  assign gb       = in_range ? (MASK_W'(1) << ant_m1[5:3]) : '0;
  assign a_hit    = |(gb & cfg.a_mask);
  assign b_hit    = |(gb & cfg.b_mask);

  // Bit offset of the port within the port bytes in eight-by-four mode.
  assign ofs = {1'b0, ant_m1[2:1], ant_m1[0], 2'b00};

  // Relay bits driven by this radio position.
  always_comb begin
    contrib = '0;
    if (cfg.two_by_four) begin
      if (a_hit) begin
        contrib[BUS_BIT]      = 1'b1;
        contrib[BYTE_LO+PAIR] = 1'b1;
      end else if (b_hit) begin
        contrib[BUS_BIT]        = 1'b1;
        contrib[BYTE_LO+PAIR+4] = 1'b1;
      end
    end else if (a_hit) begin
      contrib[BUS_BIT]           = 1'b1;
      contrib[ofs + 6'(PAIR)]    = 1'b1;
      if ((POS % 2) != 0) begin
        contrib[ofs + 6'(POS)] = 1'b1;
      end
    end
  end

  assign img_out = img_in | contrib;

endmodule

>>> hdl/antenna_relay_matrix_mapper.sv
// ----------------------------------------------------------------------------
// Antenna relay matrix mapper
// Keeps the antenna chosen by each radio of a bank of four and rebuilds the
// 40-bit relay image whenever a selection changes or a soft reset arrives.
//
//   Channel | Handshake              | Payload
//   --------+------------------------+--------------------------------------
//   input   | in_valid / in_ready    | op, radio_number, antenna_number
//   output  | out_valid / out_ready  | relay_image
//   config  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One input beat per cycle is sustained while the output register is not
// stalled. An accepted beat updates the row of cells and marks a result as
// pending; the image gathered along the row is registered once the output
// register is free. A pending result waits in one holding stage; in_ready
// falls only while that stage is full and the output register is stalled.
// Synchronous reset clears the store, the configuration and the pending and output valid flags.
// ----------------------------------------------------------------------------
module antenna_relay_matrix_mapper
  import arm_pkg::*;
#(
  parameter int RADIOS = NUM_RADIOS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  op,
  input  logic [RADIO_W-1:0]    radio_number,
  input  logic [ANT_W-1:0]      antenna_number,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [IMG_W-1:0]      relay_image,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(RADIOS);

  logic              radio_bank;
  logic [MASK_W-1:0] group_a_mask;
  logic [MASK_W-1:0] group_b_mask;
  logic              force_two_by_four;
  logic              pend;

  map_cfg_t          cfg;
  cell_ctrl_t        ctrl;
  logic              in_fire;
  logic              load;
  logic [RADIO_W-1:0] radm1;
  logic              in_bank;
  logic [IDX_W-1:0]  idx;
  logic [RADIOS-1:0] same_v;
  logic [IMG_W-1:0]  chain [0:RADIOS];

  // Configuration registers, always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radio_bank        <= 1'b0;
      group_a_mask      <= '0;
      group_b_mask      <= '0;
      force_two_by_four <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_RADIO_BANK:   radio_bank        <= cfg_data[0];
        CFG_GROUP_A_MASK: group_a_mask      <= cfg_data[MASK_W-1:0];
        CFG_GROUP_B_MASK: group_b_mask      <= cfg_data[MASK_W-1:0];
        CFG_FORCE_TWO:    force_two_by_four <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Mode selection shared by all cells.
  assign cfg.two_by_four = force_two_by_four || (group_b_mask != '0) ||
                           ((group_a_mask & (group_a_mask - MASK_W'(1))) != '0);
  assign cfg.a_mask      = group_a_mask;
  assign cfg.b_mask      = group_b_mask;

  // Handshake: a beat may enter while the pending result moves out.
  assign load     = pend && (!out_valid || out_ready);
  assign in_ready = !pend || load;
  assign in_fire  = in_valid && in_ready;

  // Position of the radio within the configured bank.
  assign radm1   = radio_number - RADIO_W'(1);
  assign in_bank = (radio_number != '0) &&
                   ((radm1 >> IDX_W) == RADIO_W'(radio_bank));
  assign idx     = radm1[IDX_W-1:0];

  // Store update command for the row.
  assign ctrl.clr = in_fire && (op == OP_SOFT_RESET);
  assign ctrl.wr  = in_fire && (op == OP_REPORT) && in_bank && !same_v[idx];
  assign ctrl.ant = antenna_number;

  // Row of cells, each adding its relay bits to the image passed along.
  assign chain[0] = '0;

  for (genvar i = 0; i < RADIOS; i++) begin : g_cell
    arm_cell #(
      .POS (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .sel     (idx == IDX_W'(i)),
      .ctrl    (ctrl),
      .cfg     (cfg),
      .img_in  (chain[i]),
      .img_out (chain[i+1]),
      .same    (same_v[i])
    );
  end

  // A result is owed after a soft reset or a changed selection.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (in_fire) begin
      pend <= ctrl.clr || ctrl.wr;
    end else if (load) begin
      pend <= 1'b0;
    end
  end

  // Output register holding the rebuilt image.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      relay_image <= chain[RADIOS];
    end
  end

endmodule

>>> hdl/arm_checker.sv
// ----------------------------------------------------------------------------
// Antenna relay matrix mapper checker
// Port-level checks on handshake behaviour and relay image consistency.
// ----------------------------------------------------------------------------
`include "antenna_relay_matrix_mapper_macros.svh"

module arm_checker
  import arm_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [IMG_W-1:0] relay_image
);

  // A stalled result beat holds its image.
  `ARM_ASSERT_NXT(a_out_hold, !rst && out_valid && !out_ready, out_valid && $stable(relay_image), "stalled result beat changed")

  // After reset no result is shown and input is open.
  `ARM_ASSERT_NXT(a_reset_idle, rst, !out_valid && in_ready, "block not idle after reset")

  // Input is only refused while a result is held up downstream.
  `ARM_ASSERT_IMP(a_ready_stall, !rst && !in_ready, out_valid && !out_ready, "input refused without output stall")

  // Bus relays are set exactly when port relays are, and only four bus relays exist.
  `ARM_ASSERT_IMP(a_image_shape, !rst && out_valid, (relay_image[39:36] == 4'd0) && ((relay_image[35:32] == 4'd0) == (relay_image[31:0] == 32'd0)), "inconsistent relay image")

endmodule

bind antenna_relay_matrix_mapper arm_checker u_arm_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .relay_image (relay_image)
);
